// ===== design/min_max_eleven_level_quantizer_defines.svh =====
// Assertion macros shared by the quantizer RTL.
// Define NO_ASSERTIONS to compile every check away; no other dependencies.
`ifndef MIN_MAX_ELEVEN_LEVEL_QUANTIZER_DEFINES_SVH
`define MIN_MAX_ELEVEN_LEVEL_QUANTIZER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check prop on every clock edge outside reset.
`define MMQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that prop holds in the cycle after cond.
`define MMQ_ASSERT_NEXT(lbl, clk, rst, cond, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`else

`define MMQ_ASSERT(lbl, clk, rst, prop, msg)
`define MMQ_ASSERT_NEXT(lbl, clk, rst, cond, prop, msg)

`endif

`endif

// ===== design/mmq_pkg.sv =====
// Shared types and constants of the eleven-level quantizer.
// No dependencies; used by mmq_step_div and the top level.
package mmq_pkg;

   localparam int LEVELS     = 11;
   localparam int LEVEL_BITS = 4;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 4'd11;

   // kind of input word, carried in tuser
   localparam logic OP_MEASURE  = 1'b0;
   localparam logic OP_CLASSIFY = 1'b1;

   localparam int REQ_USER_BITS = 2;
   localparam int USER_OP       = 0;
   localparam int USER_FIRST    = 1;

   // register file
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 32;
   localparam logic [CSR_INDEX_BITS-1:0] REG_INITIAL_MAX = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PLATE_MODE  = 1'd1;
   localparam logic signed [CSR_DATA_BITS-1:0] INITIAL_MAX_RESET = 32'sh8000_0000;

   // result word layout
   localparam int RANGE_BITS    = 32;
   localparam int RSP_DATA_BITS = 72;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - LEVEL_BITS - 2 * RANGE_BITS;

   typedef struct packed {
      logic pp_load;    // advance the partial product stage
      logic step_load;  // advance the quotient stage
   } div_ctrl_type;

endpackage

// ===== design/min_max_eleven_level_quantizer.sv =====
// Eleven-level min/max quantizer: input register, range tracking, bin width,
// thresholds and level compare. Depends on mmq_pkg, mmq_step_div and the defines header.
//
// Usage:
//   req_ channel carries one sample word per transfer. tuser[0] selects a measure
//   word (0) or a classify word (1); tuser[1] marks the first measure word of a
//   pass, which restarts the maximum from initial_max and the minimum from the
//   most positive sample value. Measure words update the running extremes and
//   return nothing. The first classify word after a measure pass latches the
//   range; every classify word returns one rsp_ word with its level (1..11,
//   0 when outside the range) and the latched range limits.
//   csr_ writes initial_max (index 0) and plate_mode (index 1); write only idle.
//   A classify word passes through the input, range, partial product, quotient,
//   threshold and output registers on its way to rsp_.
//   Throughput: one word per cycle unless rsp_ stalls, as the range update at
//   the input register is combinational; measure and classify words may follow
//   each other freely. A stalled rsp_ channel holds its word; empty stages in the
//   pipe still fill, so req_tready drops only once all six registers hold classify words.
//   Reset clears the pipe, the range state and both registers to their defaults.
`include "min_max_eleven_level_quantizer_defines.svh"

module min_max_eleven_level_quantizer #(
   parameter int SAMPLE_BITS = 32
) (
   input  logic                                        clock,
   input  logic                                        reset,
   // request channel
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]            req_tdata,  // sample
   input  logic [mmq_pkg::REQ_USER_BITS-1:0]           req_tuser,  // op, first
   // response channel
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   output logic [mmq_pkg::RSP_DATA_BITS-1:0]           rsp_tdata,  // level, range_low, range_high
   // register write port
   input  logic                                        csr_we,
   input  logic [mmq_pkg::CSR_INDEX_BITS-1:0]          csr_index,
   input  logic [mmq_pkg::CSR_DATA_BITS-1:0]           csr_wdata
);

   localparam int INT_BITS  = (SAMPLE_BITS > mmq_pkg::CSR_DATA_BITS) ?
                              SAMPLE_BITS : mmq_pkg::CSR_DATA_BITS;
   localparam int STEP_BITS = INT_BITS - 3;
   localparam int NUM_THR   = mmq_pkg::LEVELS - 1;
   localparam logic signed [INT_BITS-1:0] MOST_POS =
      INT_BITS'({1'b0, {(SAMPLE_BITS-1){1'b1}}});

   // registers
   logic signed [mmq_pkg::CSR_DATA_BITS-1:0] initial_max_ff;
   logic                                     plate_mode_ff;

   // range state
   logic signed [INT_BITS-1:0] high_mark_ff, high_mark_in;
   logic signed [INT_BITS-1:0] low_mark_ff, low_mark_in;
   logic                       classify_ready_ff, classify_ready_in;

   // pipe valid bits and stage room
   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, e_valid_ff, rsp_valid_ff;
   logic a_room, b_room, c_room, d_room, e_room, out_room, a_leave;

   // input stage
   logic                       a_op_ff, a_first_ff;
   logic signed [INT_BITS-1:0] a_sample_ff;
   logic signed [INT_BITS-1:0] a_lo, a_hi, high_base, low_base, initial_max_ext;

   // later stages
   logic signed [INT_BITS-1:0] b_v_ff, b_lo_ff, b_hi_ff;
   logic [INT_BITS-1:0]        b_diff_ff;
   logic signed [INT_BITS-1:0] c_v_ff, c_lo_ff, c_hi_ff;
   logic signed [INT_BITS-1:0] d_v_ff, d_lo_ff, d_hi_ff;
   logic [STEP_BITS-1:0]       d_step;
   logic signed [INT_BITS-1:0] e_v_ff, e_lo_ff, e_hi_ff;
   logic signed [INT_BITS:0]   e_thr_ff [1:NUM_THR];
   logic signed [INT_BITS:0]   thr_in [1:NUM_THR];
   logic [INT_BITS:0]          thr_ofs;

   // output register
   logic [mmq_pkg::LEVEL_BITS-1:0] rsp_level_ff, rsp_level_in;
   logic [mmq_pkg::LEVEL_BITS-1:0] thr_count;
   logic [mmq_pkg::RANGE_BITS-1:0] rsp_lo_ff, rsp_hi_ff;

   mmq_pkg::div_ctrl_type div_ctrl;

   // ---------------------------------------------------------------- handshake
   assign out_room = ~rsp_valid_ff | rsp_tready;
   assign e_room   = ~e_valid_ff | out_room;
   assign d_room   = ~d_valid_ff | e_room;
   assign c_room   = ~c_valid_ff | d_room;
   assign b_room   = ~b_valid_ff | c_room;
   // measure words retire at the input stage
   assign a_leave  = a_valid_ff & ((a_op_ff == mmq_pkg::OP_MEASURE) | b_room);
   assign a_room   = ~a_valid_ff | a_leave;

   assign req_tready = a_room;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{mmq_pkg::RSP_PAD_BITS{1'b0}}, rsp_hi_ff, rsp_lo_ff, rsp_level_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         e_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (a_room)   a_valid_ff   <= req_tvalid;
         if (b_room)   b_valid_ff   <= a_valid_ff & (a_op_ff == mmq_pkg::OP_CLASSIFY);
         if (c_room)   c_valid_ff   <= b_valid_ff;
         if (d_room)   d_valid_ff   <= c_valid_ff;
         if (e_room)   e_valid_ff   <= d_valid_ff;
         if (out_room) rsp_valid_ff <= e_valid_ff;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         initial_max_ff <= mmq_pkg::INITIAL_MAX_RESET;
         plate_mode_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            mmq_pkg::REG_INITIAL_MAX: initial_max_ff <= csr_wdata;
            mmq_pkg::REG_PLATE_MODE:  plate_mode_ff  <= csr_wdata[0];
         endcase
      end
   end

   // ---------------------------------------------------------------- input stage
   always_ff @(posedge clock) begin
      if (req_tvalid && a_room) begin
         a_op_ff     <= req_tuser[mmq_pkg::USER_OP];
         a_first_ff  <= req_tuser[mmq_pkg::USER_FIRST];
         a_sample_ff <= INT_BITS'(signed'(req_tdata[SAMPLE_BITS-1:0]));
      end
   end

   assign initial_max_ext = INT_BITS'(initial_max_ff);

   always_comb begin
      high_base         = a_first_ff ? initial_max_ext : high_mark_ff;
      low_base          = a_first_ff ? MOST_POS : low_mark_ff;
      a_lo              = low_mark_ff;
      a_hi              = high_mark_ff;
      high_mark_in      = high_mark_ff;
      low_mark_in       = low_mark_ff;
      classify_ready_in = classify_ready_ff;
      if (a_op_ff == mmq_pkg::OP_MEASURE) begin
         high_mark_in      = (a_sample_ff > high_base) ? a_sample_ff : high_base;
         low_mark_in       = (a_sample_ff < low_base) ? a_sample_ff : low_base;
         classify_ready_in = 1'b0;
      end else begin
         // latch the range on the first classify word of a pass
         if (!classify_ready_ff) begin
            if (plate_mode_ff) begin
               a_lo = '0;
               a_hi = '0;
            end else begin
               a_hi = high_mark_ff;
               a_lo = (low_mark_ff < high_mark_ff) ? low_mark_ff : high_mark_ff;
            end
         end
         high_mark_in      = a_hi;
         low_mark_in       = a_lo;
         classify_ready_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_mark_ff      <= INT_BITS'(mmq_pkg::INITIAL_MAX_RESET);
         low_mark_ff       <= MOST_POS;
         classify_ready_ff <= 1'b0;
      end else if (a_leave) begin
         high_mark_ff      <= high_mark_in;
         low_mark_ff       <= low_mark_in;
         classify_ready_ff <= classify_ready_in;
      end
   end

   // ---------------------------------------------------------------- width of one bin
   always_ff @(posedge clock) begin
      if (b_room) begin
         b_v_ff    <= a_sample_ff;
         b_lo_ff   <= a_lo;
         b_hi_ff   <= a_hi;
         b_diff_ff <= a_hi - a_lo;
      end
      if (c_room) begin
         c_v_ff  <= b_v_ff;
         c_lo_ff <= b_lo_ff;
         c_hi_ff <= b_hi_ff;
      end
      if (d_room) begin
         d_v_ff  <= c_v_ff;
         d_lo_ff <= c_lo_ff;
         d_hi_ff <= c_hi_ff;
      end
   end

   assign div_ctrl.pp_load   = c_room;
   assign div_ctrl.step_load = d_room;

   mmq_step_div #(
      .DIV_BITS (INT_BITS)
   ) u_step_div (
      .clock (clock),
      .ctrl  (div_ctrl),
      .diff  (b_diff_ff),
      .step  (d_step)
   );

   // ---------------------------------------------------------------- bin thresholds
   always_comb begin
      thr_ofs = '0;
      for (int k = 1; k <= NUM_THR; k++) begin
         thr_ofs   = (INT_BITS+1)'(d_step) * (INT_BITS+1)'(k);
         thr_in[k] = (INT_BITS+1)'(d_lo_ff) + signed'(thr_ofs);
      end
   end

   always_ff @(posedge clock) begin
      if (e_room) begin
         e_v_ff   <= d_v_ff;
         e_lo_ff  <= d_lo_ff;
         e_hi_ff  <= d_hi_ff;
         e_thr_ff <= thr_in;
      end
   end

   // ---------------------------------------------------------------- level
   always_comb begin
      thr_count = '0;
      for (int k = 1; k <= NUM_THR; k++) begin
         if (e_thr_ff[k] <= (INT_BITS+1)'(e_v_ff)) begin
            thr_count = thr_count + 1'b1;
         end
      end
      if (e_v_ff >= e_lo_ff && e_v_ff <= e_hi_ff) begin
         rsp_level_in = thr_count + 1'b1;
      end else begin
         rsp_level_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_room) begin
         rsp_level_ff <= rsp_level_in;
         rsp_lo_ff    <= e_lo_ff[mmq_pkg::RANGE_BITS-1:0];
         rsp_hi_ff    <= e_hi_ff[mmq_pkg::RANGE_BITS-1:0];
      end
   end

   // ---------------------------------------------------------------- checks
   `MMQ_ASSERT(a_level_bound, clock, reset,
      rsp_valid_ff |-> rsp_level_ff <= mmq_pkg::LEVEL_MAX, "level above eleven")
   `MMQ_ASSERT_NEXT(a_range_latched, clock, reset,
      a_leave && a_op_ff == mmq_pkg::OP_CLASSIFY, classify_ready_ff,
      "range not latched after classify word")
   `MMQ_ASSERT_NEXT(a_range_held, clock, reset,
      classify_ready_ff && !(a_leave && a_op_ff == mmq_pkg::OP_MEASURE),
      $stable(high_mark_ff) && $stable(low_mark_ff), "latched range moved")
   `MMQ_ASSERT(a_range_order, clock, reset,
      classify_ready_ff |-> low_mark_ff <= high_mark_ff, "latched range inverted")

endmodule

// ===== design/mmq_step_div.sv =====
// Two-stage divide-by-eleven pipeline giving the bin width of the range.
// Depends on mmq_pkg (div_ctrl_type); the top level supplies the stage enables.
module mmq_step_div #(
   parameter int DIV_BITS = 32
) (
   input  logic                       clock,
   input  mmq_pkg::div_ctrl_type      ctrl,
   input  logic [DIV_BITS-1:0]        diff,
   output logic [DIV_BITS-4:0]        step
);

   // floor(n / 11) = (n * RECIP) >> SHIFT for every n below 2**DIV_BITS
   localparam int SHIFT   = DIV_BITS + 4;
   localparam int SPLIT   = (DIV_BITS + 2) / 2;
   localparam int HI_BITS = DIV_BITS + 1 - SPLIT;
   localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) + 64'd10) / 64'd11;
   localparam logic [DIV_BITS:0]    RECIP    = RECIP_FULL[DIV_BITS:0];
   localparam logic [SPLIT-1:0]     RECIP_LO = RECIP[SPLIT-1:0];
   localparam logic [HI_BITS-1:0]   RECIP_HI = RECIP[DIV_BITS:SPLIT];

   logic [DIV_BITS+SPLIT-1:0]   pp_lo_ff;
   logic [DIV_BITS+HI_BITS-1:0] pp_hi_ff;
   logic [2*DIV_BITS:0]         sum;
   logic [DIV_BITS-4:0]         step_ff;

   always_ff @(posedge clock) begin
      if (ctrl.pp_load) begin
         pp_lo_ff <= (DIV_BITS+SPLIT)'(diff) * (DIV_BITS+SPLIT)'(RECIP_LO);
         pp_hi_ff <= (DIV_BITS+HI_BITS)'(diff) * (DIV_BITS+HI_BITS)'(RECIP_HI);
      end
      if (ctrl.step_load) begin
         step_ff <= sum[2*DIV_BITS:SHIFT];
      end
   end

   assign sum  = {pp_hi_ff, {SPLIT{1'b0}}} + (2*DIV_BITS+1)'(pp_lo_ff);
   assign step = step_ff;

endmodule
